@@ rtl/mbcc_pkg.sv @@
// Shared constants for the multi-button click classifier.
// No dependencies.
`timescale 1ns / 1ps
package mbcc_pkg;
  localparam logic [15:0] SAT16 = 16'hFFFF;
  localparam logic KIND_CLICK = 1'b0;
  localparam logic KIND_LONG = 1'b1;
  localparam logic ACT_SAMPLE = 1'b0;
  localparam logic ACT_FETCH = 1'b1;
  localparam logic [2:0] REG_ENABLE = 3'd0;
  localparam logic [2:0] REG_ACTIVE = 3'd1;
  localparam logic [2:0] REG_CLICK = 3'd2;
  localparam logic [2:0] REG_LONG = 3'd3;
  localparam logic [2:0] REG_WINDOW = 3'd4;
  localparam int EVT_W = 44;
endpackage

@@ rtl/mbcc_ram.sv @@
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module mbcc_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

@@ rtl/multi_button_click_classifier.sv @@
// Top level of the multi-button click classifier: sequencer, button state and event queue.
// Depends on mbcc_pkg and mbcc_ram.
`timescale 1ns / 1ps
// Usage:
// One input channel (valid/ready) carries an action, a time stamp and the pin
// levels. Action 0 samples the pins, action 1 fetches the next event. Every item
// gives exactly one result item on the output channel (valid/ready).
// A sample walks the buttons one per cycle, but a release that makes an event
// holds the walk while the event is queued (ST_WRITE), and an event with a
// count above one first scans the queued entries through the event RAM read
// port, in ST_SCAN and ST_SCAN_CHK for each entry. All buttons share the
// single duration adder. A fetch reads the queue head through the registered
// RAM read port (ST_FETCH, ST_FETCH_RD), or goes straight to the result on an
// empty queue; a click still inside the window is requeued, with no event out.
// The block takes one item at a time; it is ready again the cycle after its
// result is taken, and it holds that result as long as the receiver stalls,
// without taking a new item. Reset clears all button state, the queue pointers
// and the overflow flag and restores the register defaults; configuration
// writes take effect at once.
module multi_button_click_classifier #(
  parameter int NUM_BUTTONS = 8,
  parameter int QUEUE_DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        action_i,
  input  logic [31:0] now_ms_i,
  input  logic [7:0]  pin_levels_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        event_valid_o,
  output logic [2:0]  event_button_o,
  output logic        event_kind_o,
  output logic [7:0]  event_count_o,
  output logic        overflow_o
);
  localparam int QW = $clog2(QUEUE_DEPTH);
  localparam int FW = $clog2(QUEUE_DEPTH + 1);
  localparam int SW = FW + 1;
  localparam int NB = (NUM_BUTTONS < 8) ? NUM_BUTTONS : 8;
  localparam int BW = (NB > 1) ? $clog2(NB) : 1;

  typedef enum logic [3:0] {
    ST_IDLE, ST_BTN, ST_SCAN, ST_SCAN_CHK, ST_WRITE, ST_FETCH, ST_FETCH_RD, ST_OUT
  } state_e;

  state_e state_q;
  logic [7:0] en_q, act_q;
  logic [15:0] click_q, long_q, win_q;
  logic [15:0] dur_q [NB];
  logic [NB-1:0] prs_q;
  logic [7:0] run_q [NB];
  logic [31:0] last_q, now_q, elap_q;
  logic [7:0] pins_q;
  logic [QW-1:0] head_q;
  logic [FW-1:0] fill_q, k_q;
  logic drop_q;
  logic [BW-1:0] bi_q;
  logic [mbcc_pkg::EVT_W-1:0] ev_q;
  logic found_q;
  logic [QW-1:0] hit_q;
  logic ov_q, vld_q, ek_q;
  logic [2:0] eb_q;
  logic [7:0] ec_q;

  // RAM
  logic we;
  logic [QW-1:0] waddr, raddr;
  logic [mbcc_pkg::EVT_W-1:0] wdata, rdata;
  mbcc_ram #(.Width(mbcc_pkg::EVT_W), .Depth(QUEUE_DEPTH)) u_ram (
    .clk_i(clk_i), .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  // entry fields: {button[2:0], kind, count[7:0], stamp[31:0]}
  logic [2:0] r_btn; logic r_kind; logic [7:0] r_cnt; logic [31:0] r_stamp;
  assign {r_btn, r_kind, r_cnt, r_stamp} = rdata;

  // fold a slot sum back into the queue; the sum stays below twice the depth
  function automatic logic [QW-1:0] wrap_slot(logic [SW-1:0] s);
    logic [SW-1:0] w;
    w = (s >= SW'(QUEUE_DEPTH)) ? s - SW'(QUEUE_DEPTH) : s;
    return w[QW-1:0];
  endfunction

  logic [SW-1:0] slot_sum, rs;
  logic [QW-1:0] tail, rslot;
  assign slot_sum = SW'(head_q) + SW'(fill_q);
  assign tail = wrap_slot(slot_sum);
  assign rs = SW'(head_q) + SW'(k_q);
  assign rslot = wrap_slot(rs);
  assign raddr = (state_q == ST_FETCH) ? head_q : rslot;

  // per-button step
  logic [16:0] dsum;
  logic [15:0] dsat;
  logic down, en_b;
  logic [7:0] run_inc;
  assign en_b = en_q[bi_q];
  assign dsum = {1'b0, dur_q[bi_q]} + 17'(elap_q[15:0]);
  assign dsat = ((elap_q[31:16] != 16'd0) || dsum >= 17'(mbcc_pkg::SAT16)) ?
                mbcc_pkg::SAT16 : dsum[15:0];
  assign down = (pins_q[bi_q] == act_q[bi_q]);
  assign run_inc = run_q[bi_q] + 8'd1;

  logic [31:0] age;
  assign age = now_q - r_stamp;

  always_comb begin
    we = 1'b0; waddr = tail; wdata = ev_q;
    if (state_q == ST_WRITE) begin
      we = found_q || (fill_q < FW'(QUEUE_DEPTH));
      waddr = found_q ? hit_q : tail;
    end else if (state_q == ST_FETCH_RD) begin
      we = (r_kind == mbcc_pkg::KIND_CLICK) && (age < {16'd0, win_q});
      waddr = tail; wdata = rdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      en_q <= '0; act_q <= '0;
      click_q <= 16'd50; long_q <= 16'd1000; win_q <= 16'd400;
      for (int i = 0; i < NB; i++) begin
        dur_q[i] <= '0; run_q[i] <= '0;
      end
      prs_q <= '0; last_q <= '0; head_q <= '0; fill_q <= '0; drop_q <= 1'b0;
      vld_q <= 1'b0;
      now_q <= '0; pins_q <= '0; elap_q <= '0; bi_q <= '0; ev_q <= '0;
      found_q <= 1'b0; hit_q <= '0; k_q <= '0;
      eb_q <= '0; ek_q <= 1'b0; ec_q <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          mbcc_pkg::REG_ENABLE: begin
            for (int i = 0; i < NB; i++) begin
              if (cfg_data_i[i] && !en_q[i]) begin
                prs_q[i] <= 1'b0; dur_q[i] <= '0;
              end
            end
            en_q <= cfg_data_i[7:0];
          end
          mbcc_pkg::REG_ACTIVE: act_q <= cfg_data_i[7:0];
          mbcc_pkg::REG_CLICK: click_q <= cfg_data_i;
          mbcc_pkg::REG_LONG: long_q <= cfg_data_i;
          mbcc_pkg::REG_WINDOW: win_q <= cfg_data_i;
          default: ;
        endcase
      end
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            now_q <= now_ms_i; pins_q <= pin_levels_i;
            elap_q <= now_ms_i - last_q;
            bi_q <= '0;
            vld_q <= 1'b0; eb_q <= '0; ek_q <= 1'b0; ec_q <= '0;
            state_q <= (action_i == mbcc_pkg::ACT_FETCH) ?
                       ((fill_q != '0) ? ST_FETCH : ST_OUT) : ST_BTN;
          end
        end
        ST_BTN: begin
          if (en_b) begin
            dur_q[bi_q] <= dsat;
            if (down) begin
              if (!prs_q[bi_q]) begin
                if (dsat > win_q) run_q[bi_q] <= '0;
                dur_q[bi_q] <= '0; prs_q[bi_q] <= 1'b1;
              end
            end else if (prs_q[bi_q]) begin
              prs_q[bi_q] <= 1'b0; dur_q[bi_q] <= '0;
              if (dsat >= long_q) begin
                ev_q <= {3'(bi_q), mbcc_pkg::KIND_LONG, run_q[bi_q], now_q};
                run_q[bi_q] <= '0;
                state_q <= (run_q[bi_q] > 8'd1) ? ST_SCAN : ST_WRITE;
              end else if (dsat >= click_q) begin
                ev_q <= {3'(bi_q), mbcc_pkg::KIND_CLICK, run_inc, now_q};
                run_q[bi_q] <= run_inc;
                state_q <= (run_inc > 8'd1) ? ST_SCAN : ST_WRITE;
              end
            end
          end
          k_q <= '0; found_q <= 1'b0;
          if (state_q == ST_BTN && !(en_b && !down && prs_q[bi_q] &&
              (dsat >= click_q || dsat >= long_q))) begin
            if (32'(bi_q) == NB - 1) begin
              last_q <= now_q; state_q <= ST_OUT;
            end else bi_q <= bi_q + 1'b1;
          end
        end
        ST_SCAN: begin
          // address for entry k is presented; data next cycle
          state_q <= (k_q < fill_q) ? ST_SCAN_CHK : ST_WRITE;
        end
        ST_SCAN_CHK: begin
          if (r_btn == ev_q[43:41] && r_kind == mbcc_pkg::KIND_CLICK &&
              (r_cnt + 8'd1) == ev_q[39:32] && r_cnt != 8'hFF) begin
            found_q <= 1'b1; hit_q <= rslot;
          end
          k_q <= k_q + 1'b1;
          state_q <= ST_SCAN;
        end
        ST_WRITE: begin
          if (!found_q) begin
            if (fill_q < FW'(QUEUE_DEPTH)) fill_q <= fill_q + 1'b1;
            else drop_q <= 1'b1;
          end
          if (32'(bi_q) == NB - 1) begin
            last_q <= now_q; state_q <= ST_OUT;
          end else begin
            bi_q <= bi_q + 1'b1; state_q <= ST_BTN;
          end
        end
        ST_FETCH: begin
          state_q <= ST_FETCH_RD;
        end
        ST_FETCH_RD: begin
          head_q <= (head_q == QW'(QUEUE_DEPTH - 1)) ? '0 : head_q + 1'b1;
          if (!we) begin
            fill_q <= fill_q - 1'b1;
            vld_q <= 1'b1; eb_q <= r_btn; ek_q <= r_kind; ec_q <= r_cnt;
          end
          state_q <= ST_OUT;
        end
        ST_OUT: begin
          if (out_ready_i) state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);
  assign out_valid_o = (state_q == ST_OUT);
  assign event_valid_o = vld_q;
  assign event_button_o = eb_q;
  assign event_kind_o = ek_q;
  assign event_count_o = ec_q;
  assign overflow_o = drop_q;

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FW'(QUEUE_DEPTH)) else $error("fill beyond depth");
  a_drop_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    drop_q |=> drop_q) else $error("overflow cleared");
  a_no_both: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o)) else $error("ready while result held");
  a_empty_none: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !vld_q) |-> (eb_q == 3'd0 && ec_q == 8'd0))
    else $error("payload without event");
endmodule
